### hw/rtl/lzo_pkg.sv
// layer z-order manager package: widths, request and status codes,
// control and status structs shared by the sequencer and the step counter
// depends on nothing
`default_nettype none

package lzo_pkg;

    localparam int MAX_LAYERS = 16;
    localparam int SLOT_W     = 4;
    localparam int HEIGHT_W   = 5;
    localparam int CNT_W      = 5;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_UNUSED = 2'd2;

    localparam logic signed [HEIGHT_W-1:0] HIDDEN = -5'sd1;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              up;
        logic [SLOT_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } step_ctl_t;

    typedef struct packed {
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0] nxt2;
        logic              last;
        logic              empty;
    } step_stat_t;

endpackage

`default_nettype wire

### hw/rtl/layer_z_order_manager.sv
// request flow, input transfer to result: allocate goes idle, scan, done (one slot scanned a cycle)
// set height / free that moves a layer: idle, eval, prime, shift once per layer shifted (at most 15), final, done
// query, rejected and unchanged requests: idle, eval, done; next request accepted once idle
// one request in flight at a time; a result not yet taken holds the sequencer in done
// reset (asynchronous, active low): all slots free, all heights hidden, no visible layers;
// the stack order memory is not cleared, only entries below the visible count are read
`default_nettype none

module layer_z_order_manager (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         mode,
    input  wire logic [lzo_pkg::SLOT_W-1:0]         slot,
    input  wire logic signed [lzo_pkg::HEIGHT_W-1:0] height,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [1:0]                              status,
    output logic [lzo_pkg::SLOT_W-1:0]              slot_out,
    output logic signed [lzo_pkg::HEIGHT_W-1:0]     height_out,
    output logic [lzo_pkg::CNT_W-1:0]               visible_count
);
    import lzo_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PRIME = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // per-slot state: in-use flags and heights live in flops
    logic [MAX_LAYERS-1:0]         in_use_reg;
    logic signed [HEIGHT_W-1:0]    height_reg [MAX_LAYERS];
    logic [CNT_W-1:0]              vt_reg;

    // latched request
    logic [1:0]                    mode_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic signed [HEIGHT_W-1:0]    req_reg;

    // move bookkeeping
    logic signed [HEIGHT_W-1:0]    tgt_reg;
    logic                          ins_reg;
    logic                          vt_inc_reg;
    logic                          vt_dec_reg;

    // pending result
    logic [1:0]                    res_status_reg;
    logic [SLOT_W-1:0]             res_slot_reg;
    logic signed [HEIGHT_W-1:0]    res_height_reg;

    logic in_xfer;
    logic out_free;

    // shared step counter and order memory
    step_ctl_t  step_ctl;
    step_stat_t step_stat;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [SLOT_W-1:0] mem_wdata;
    logic [SLOT_W-1:0] mem_raddr;
    logic [SLOT_W-1:0] mem_rdata;

    // evaluation of a set-height or free request
    logic signed [HEIGHT_W-1:0] old_h;
    logic signed [CNT_W:0]      old6;
    logic signed [CNT_W:0]      vt6;
    logic signed [CNT_W:0]      top6;
    logic signed [CNT_W:0]      req6;
    logic signed [CNT_W:0]      clamp6;
    logic signed [CNT_W:0]      tgt6;
    logic                       slot_ok;
    logic                       mv_ins;
    logic                       mv_inc;
    logic                       mv_dec;
    logic                       mv_up;
    logic [SLOT_W-1:0]          mv_start;
    logic signed [CNT_W:0]      mv_diff;

    // visibility flags, used by the consistency checks
    logic [MAX_LAYERS-1:0] vis_vec;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;

    lzo_step_unit u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (step_ctl),
        .stat  (step_stat)
    );

    lzo_order_mem u_order (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // clamp the requested height and pick the shift direction
    always_comb
    begin
        old_h   = height_reg[slot_reg];
        slot_ok = in_use_reg[slot_reg];
        old6    = (CNT_W+1)'(old_h);
        vt6     = signed'({1'b0, vt_reg});
        req6    = (CNT_W+1)'(req_reg);
        // a visible layer may reach the top entry, a hidden one lands above it
        top6    = old_h[HEIGHT_W-1] ? vt6 : vt6 - 6'sd1;
        clamp6  = (req6 < -6'sd1) ? -6'sd1 : req6;
        tgt6    = (clamp6 > top6) ? top6 : clamp6;
        if (mode_reg == MODE_FREE)
        begin
            tgt6 = -6'sd1;
        end

        mv_ins   = 1'b1;
        mv_inc   = 1'b0;
        mv_dec   = 1'b0;
        mv_up    = 1'b0;
        mv_start = old6[SLOT_W-1:0];
        mv_diff  = old6 - tgt6;
        if (old6 > tgt6)
        begin
            if (tgt6 < 6'sd0)
            begin
                // leaving the visible stack: close the gap above
                mv_ins  = 1'b0;
                mv_dec  = 1'b1;
                mv_up   = 1'b1;
                mv_diff = vt6 - 6'sd1 - old6;
            end
        end
        else if (old6 >= 6'sd0)
        begin
            // moving up inside the stack
            mv_up   = 1'b1;
            mv_diff = tgt6 - old6;
        end
        else
        begin
            // entering the visible stack: open a gap at the target
            mv_inc   = 1'b1;
            mv_start = vt_reg[SLOT_W-1:0];
            mv_diff  = vt6 - tgt6;
        end
    end

    // next state and step counter control
    always_comb
    begin
        state_next     = state_reg;
        step_ctl       = '0;
        step_ctl.start = mv_start;
        step_ctl.count = mv_diff[CNT_W-1:0];
        step_ctl.up    = mv_up;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (mode == MODE_ALLOC)
                    begin
                        // scan slots upward from slot zero
                        step_ctl.load  = 1'b1;
                        step_ctl.up    = 1'b1;
                        step_ctl.start = '0;
                        step_ctl.count = CNT_W'(MAX_LAYERS);
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                if ((mode_reg == MODE_SET || mode_reg == MODE_FREE) && slot_ok &&
                    (tgt6 != old6))
                begin
                    step_ctl.load = 1'b1;
                    state_next    = S_PRIME;
                end
            end
            S_SCAN:
            begin
                if (!in_use_reg[step_stat.cur] || step_stat.last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_ctl.step = 1'b1;
                end
            end
            S_PRIME:
            begin
                state_next = step_stat.empty ? S_FINAL : S_SHIFT;
            end
            S_SHIFT:
            begin
                step_ctl.step = 1'b1;
                if (step_stat.last)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // order memory port: shift moves one entry a cycle, read runs one step ahead
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = step_stat.cur;
        mem_wdata = mem_rdata;
        mem_raddr = step_stat.nxt;
        if (state_reg == S_SHIFT)
        begin
            mem_we    = 1'b1;
            mem_raddr = step_stat.nxt2;
        end
        else if (state_reg == S_FINAL && ins_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = tgt_reg[SLOT_W-1:0];
            mem_wdata = slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            in_use_reg <= '0;
            vt_reg     <= '0;
            out_valid  <= 1'b0;
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                height_reg[i] <= HIDDEN;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_EVAL:
                begin
                    if ((mode_reg == MODE_SET || mode_reg == MODE_FREE) && slot_ok &&
                        (tgt6 != old6))
                    begin
                        height_reg[slot_reg] <= tgt6[HEIGHT_W-1:0];
                    end
                end
                S_SCAN:
                begin
                    if (!in_use_reg[step_stat.cur])
                    begin
                        in_use_reg[step_stat.cur] <= 1'b1;
                        height_reg[step_stat.cur] <= HIDDEN;
                    end
                end
                S_SHIFT:
                begin
                    // renumber the layer that just moved
                    height_reg[mem_rdata] <= signed'({1'b0, step_stat.cur});
                end
                S_FINAL:
                begin
                    if (vt_inc_reg)
                    begin
                        vt_reg <= vt_reg + CNT_W'(1);
                    end
                    else if (vt_dec_reg)
                    begin
                        vt_reg <= vt_reg - CNT_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        if (mode_reg == MODE_FREE && res_status_reg == ST_OK)
                        begin
                            in_use_reg[slot_reg] <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (state_reg == S_DONE && out_free)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // request, move and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= mode;
            slot_reg <= slot;
            req_reg  <= height;
        end

        case (state_reg)
            S_EVAL:
            begin
                tgt_reg      <= tgt6[HEIGHT_W-1:0];
                ins_reg      <= mv_ins;
                vt_inc_reg   <= mv_inc;
                vt_dec_reg   <= mv_dec;
                res_slot_reg <= slot_reg;
                if (mode_reg == MODE_QUERY)
                begin
                    res_status_reg <= ST_OK;
                    res_height_reg <= old_h;
                end
                else if (!slot_ok)
                begin
                    res_status_reg <= ST_UNUSED;
                    res_height_reg <= HIDDEN;
                end
                else
                begin
                    res_status_reg <= ST_OK;
                    res_height_reg <= tgt6[HEIGHT_W-1:0];
                end
            end
            S_SCAN:
            begin
                res_height_reg <= HIDDEN;
                if (!in_use_reg[step_stat.cur])
                begin
                    res_status_reg <= ST_OK;
                    res_slot_reg   <= step_stat.cur;
                end
                else
                begin
                    res_status_reg <= ST_FULL;
                    res_slot_reg   <= '0;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    status        <= res_status_reg;
                    slot_out      <= res_slot_reg;
                    height_out    <= res_height_reg;
                    visible_count <= vt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            vis_vec[i] = !height_reg[i][HEIGHT_W-1];
        end
    end

    // visible count never exceeds the pool
    a_vt_range: assert property (@(posedge clk) disable iff (!rst_n)
        vt_reg <= CNT_W'(MAX_LAYERS))
        else $error("visible count beyond pool size");

    // between requests the visible count matches the layers with a height
    a_vt_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(vis_vec) == 32'(vt_reg)))
        else $error("visible count out of step with layer heights");

    // a shift step is only taken while steps remain
    a_shift_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> !step_stat.empty)
        else $error("shift ran past its step count");

    // between requests no free slot holds a visible height
    a_free_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((vis_vec & ~in_use_reg) == '0))
        else $error("free slot left in the visible stack");

    // an accepted transfer always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire

### hw/rtl/lzo_order_mem.sv
// stack order memory: slot number held at each stacking height
// one write port, one read port with registered read data; uses lzo_pkg
`default_nettype none

module lzo_order_mem (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [lzo_pkg::SLOT_W-1:0] waddr,
    input  wire logic [lzo_pkg::SLOT_W-1:0] wdata,
    input  wire logic [lzo_pkg::SLOT_W-1:0] raddr,
    output logic      [lzo_pkg::SLOT_W-1:0] rdata
);
    import lzo_pkg::*;

    logic [SLOT_W-1:0] mem [MAX_LAYERS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/lzo_step_unit.sv
// shared step counter: height cursor with direction and remaining-step count
// used for the free-slot scan and for every stack shift; uses lzo_pkg
`default_nettype none

module lzo_step_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lzo_pkg::step_ctl_t ctl,
    output lzo_pkg::step_stat_t     stat
);
    import lzo_pkg::*;

    logic [SLOT_W-1:0] h_reg;
    logic [SLOT_W-1:0] h_next;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  left_next;
    logic              up_reg;
    logic              up_next;
    logic [SLOT_W-1:0] step1;
    logic [SLOT_W-1:0] step2;

    assign step1 = up_reg ? h_reg + SLOT_W'(1) : h_reg - SLOT_W'(1);
    assign step2 = up_reg ? h_reg + SLOT_W'(2) : h_reg - SLOT_W'(2);

    always_comb
    begin
        h_next    = h_reg;
        left_next = left_reg;
        up_next   = up_reg;
        if (ctl.load)
        begin
            h_next    = ctl.start;
            left_next = ctl.count;
            up_next   = ctl.up;
        end
        else if (ctl.step)
        begin
            h_next    = step1;
            left_next = left_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg    <= '0;
            left_reg <= '0;
            up_reg   <= 1'b0;
        end
        else
        begin
            h_reg    <= h_next;
            left_reg <= left_next;
            up_reg   <= up_next;
        end
    end

    assign stat.cur   = h_reg;
    assign stat.nxt   = step1;
    assign stat.nxt2  = step2;
    assign stat.last  = (left_reg == CNT_W'(1));
    assign stat.empty = (left_reg == '0);

endmodule

`default_nettype wire
